// ===== rtl/core/brfifo_pkg.sv =====
// Shared types and codes for the byte ring FIFO.
package brfifo_pkg;

  localparam int DATA_W = 8;
  localparam int CFG_W  = 11;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_GET   = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_PUT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_GET_EMPTY = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              rd;
    logic              full;
    logic              empty;
  } res_t;

endpackage

// ===== rtl/core/brfifo_mem.sv =====
// Byte store: one write port, one registered read port.
module brfifo_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [brfifo_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [brfifo_pkg::DATA_W-1:0] rdata
);
  import brfifo_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/brfifo_ctrl.sv =====
// Ring indices, full and empty marks, ring length and store access control.
module brfifo_ctrl #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [brfifo_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                          acc,
  input  logic [brfifo_pkg::OP_W-1:0]   op,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  output brfifo_pkg::res_t              res
);
  import brfifo_pkg::*;

  localparam int LW      = AW + 1;
  localparam int CW      = (LW > CFG_W) ? LW : CFG_W;
  localparam int LEN_RST = (1024 < DEPTH) ? 1024 : DEPTH;

  logic [AW-1:0] ri_r, ri_nxt, wi_r, wi_nxt;
  logic          full_r, full_nxt, empty_r, empty_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] ri_inc, wi_inc;
  logic [AW-1:0] ri_adv, wi_adv;
  logic [CW-1:0] cfg_ext;
  logic [STAT_W-1:0] status;
  logic          rd;

  assign cfg_ext = CW'(cfg_wdata);

  always_comb begin
    if (cfg_ext == '0) begin
      len_nxt = LW'(1);
    end else if (cfg_ext > CW'(DEPTH)) begin
      len_nxt = LW'(DEPTH);
    end else begin
      len_nxt = cfg_ext[LW-1:0];
    end
  end

  assign ri_inc = {1'b0, ri_r} + LW'(1);
  assign wi_inc = {1'b0, wi_r} + LW'(1);
  assign ri_adv = (ri_inc >= len_r) ? '0 : ri_inc[AW-1:0];
  assign wi_adv = (wi_inc >= len_r) ? '0 : wi_inc[AW-1:0];

  always_comb begin
    ri_nxt    = ri_r;
    wi_nxt    = wi_r;
    full_nxt  = full_r;
    empty_nxt = empty_r;
    status    = ST_DONE;
    rd        = 1'b0;
    mem_we    = 1'b0;
    case (op)
      OP_PUT: begin
        if (full_r && !empty_r) begin
          status = ST_PUT_FULL;
        end else begin
          mem_we    = acc;
          wi_nxt    = wi_adv;
          full_nxt  = (wi_adv == ri_r);
          empty_nxt = 1'b0;
        end
      end
      OP_GET: begin
        if (empty_r) begin
          full_nxt = 1'b1;
          status   = ST_GET_EMPTY;
        end else begin
          rd        = 1'b1;
          ri_nxt    = ri_adv;
          empty_nxt = (ri_adv == wi_r);
          full_nxt  = 1'b0;
        end
      end
      OP_FLUSH: begin
        if (!empty_r) begin
          ri_nxt    = wi_r;
          empty_nxt = 1'b1;
          full_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_waddr  = wi_r;
  assign mem_re     = acc && rd;
  assign mem_raddr  = ri_r;
  assign res.status = status;
  assign res.rd     = rd;
  assign res.full   = full_nxt;
  assign res.empty  = empty_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ri_r    <= '0;
      wi_r    <= '0;
      full_r  <= 1'b0;
      empty_r <= 1'b1;
      len_r   <= LW'(LEN_RST);
    end else begin
      if (acc) begin
        ri_r    <= ri_nxt;
        wi_r    <= wi_nxt;
        full_r  <= full_nxt;
        empty_r <= empty_nxt;
      end
      if (cfg_we) begin
        len_r <= len_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/byte_ring_fifo_with_drain_flag.sv =====
// Byte ring FIFO with drain flag: top level with result stage and output register.
//
// Input channel (in_valid / in_stall) carries one item: a put, get or flush
// in in_operation, with the byte for a put in in_data_in. Each item yields
// exactly one result on the output channel (out_valid / out_stall): status,
// the byte removed by a get, and the full and empty flags after the item.
// Full and empty both set mean a get found the ring drained.
// cfg_we / cfg_wdata write the ring length; write only while the block is idle.
// The store read and the result stage load when an item is accepted; the output
// register loads from the result stage once it is free and drives out_valid.
// Throughput: one item per cycle while the receiver takes results.
// When out_stall holds a result, one more item is taken into the result stage,
// then in_stall rises until the output register frees.
// Reset: indices zero, empty set, full clear, ring length min(1024, depth);
// the byte store is not cleared and needs no clearing pass.
module byte_ring_fifo_with_drain_flag #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [brfifo_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [brfifo_pkg::OP_W-1:0]       in_operation,
  input  logic [brfifo_pkg::DATA_W-1:0]     in_data_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [brfifo_pkg::STAT_W-1:0]     out_status,
  output logic [brfifo_pkg::DATA_W-1:0]     out_data_out,
  output logic                              out_full_flag,
  output logic                              out_empty_flag
);
  import brfifo_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic              acc;
  logic              out_free;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  res_t              res;

  logic              pend_valid_r;
  res_t              pend_res_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_full_r, out_empty_r;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = pend_valid_r && !out_free;
  assign acc      = in_valid && !in_stall;

  brfifo_ctrl #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .op        (in_operation),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  brfifo_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data_in),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (acc) begin
        pend_valid_r <= 1'b1;
      end else if (out_free) begin
        pend_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= pend_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_res_r <= res;
    end
    if (out_free && pend_valid_r) begin
      out_status_r <= pend_res_r.status;
      out_data_r   <= pend_res_r.rd ? mem_rdata : '0;
      out_full_r   <= pend_res_r.full;
      out_empty_r  <= pend_res_r.empty;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data_out   = out_data_r;
  assign out_full_flag  = out_full_r;
  assign out_empty_flag = out_empty_r;

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (pend_valid_r && out_valid_r))
    else $error("input stalled without a held result");

  a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r && out_free) |=> out_valid_r)
    else $error("result stage item lost");

  a_put_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_PUT_FULL) |-> (out_full_flag && !out_empty_flag))
    else $error("refused put without full flag");

  a_get_empty_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_GET_EMPTY) |-> (out_full_flag && out_empty_flag))
    else $error("refused get without drain flags");

  a_data_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_data_out == '0))
    else $error("data on a refused item");

endmodule

// ===== dv/byte_ring_fifo_with_drain_flag_checker.sv =====
// Result checker for the byte ring FIFO: mirrors the ring and compares every result item.
`timescale 1ns / 100ps
module byte_ring_fifo_with_drain_flag_checker #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [brfifo_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [brfifo_pkg::OP_W-1:0]   in_operation,
  input  logic [brfifo_pkg::DATA_W-1:0] in_data_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [brfifo_pkg::STAT_W-1:0] out_status,
  input  logic [brfifo_pkg::DATA_W-1:0] out_data_out,
  input  logic                          out_full_flag,
  input  logic                          out_empty_flag,
  output int                            error_count,
  output int                            results_pending
);
  import brfifo_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic              full;
    logic              empty;
  } fifo_reply_t;

  logic [DATA_W-1:0] ring_bytes [STORE_DEPTH];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  logic              ring_full;
  logic              ring_empty;
  logic [CFG_W-1:0]  ring_size;
  fifo_reply_t       expected_replies [$];

  function automatic int unsigned wrap_next(input int unsigned idx);
    int unsigned len;
    len = (ring_size == 0) ? 1 : (ring_size > STORE_DEPTH) ? STORE_DEPTH : ring_size;
    return (idx + 1 >= len) ? 0 : idx + 1;
  endfunction

  function automatic fifo_reply_t apply_fifo_op(input logic [OP_W-1:0] op,
                                                input logic [DATA_W-1:0] data_byte);
    fifo_reply_t r;
    r = '0;
    r.status = ST_DONE;
    case (op)
      OP_PUT: begin
        if (ring_full && !ring_empty) begin
          r.status = ST_PUT_FULL;
        end else begin
          ring_bytes[AW'(wr_ptr)] = data_byte;
          wr_ptr = wrap_next(wr_ptr);
          ring_full = (wr_ptr == rd_ptr);
          ring_empty = 1'b0;
        end
      end
      OP_GET: begin
        if (ring_empty) begin
          ring_full = 1'b1;
          r.status = ST_GET_EMPTY;
        end else begin
          r.data = ring_bytes[AW'(rd_ptr)];
          rd_ptr = wrap_next(rd_ptr);
          if (rd_ptr == wr_ptr) ring_empty = 1'b1;
          ring_full = 1'b0;
        end
      end
      OP_FLUSH: begin
        if (!ring_empty) begin
          rd_ptr = wr_ptr;
          ring_empty = 1'b1;
          ring_full = 1'b0;
        end
      end
      default: ;
    endcase
    r.full = ring_full;
    r.empty = ring_empty;
    return r;
  endfunction

  always @(posedge clk) begin
    fifo_reply_t want;
    fifo_reply_t got;
    if (!rst_n) begin
      rd_ptr = 0;
      wr_ptr = 0;
      ring_full = 1'b0;
      ring_empty = 1'b1;
      ring_size = 11'd1024;
      expected_replies.delete();
    end else begin
      if (cfg_we) ring_size = cfg_wdata;
      if (out_valid && !out_stall) begin
        got = '{status: out_status, data: out_data_out,
                full: out_full_flag, empty: out_empty_flag};
        if (expected_replies.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected result item: status=%0d data=%02h full=%b empty=%b",
                     $time, got.status, got.data, got.full, got.empty);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: mismatch: exp st=%0d d=%02h f=%b e=%b, got st=%0d d=%02h f=%b e=%b",
                       $time, want.status, want.data, want.full, want.empty,
                       got.status, got.data, got.full, got.empty);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_replies.push_back(apply_fifo_op(in_operation, in_data_in));
    end
    results_pending = expected_replies.size();
  end

endmodule

// ===== dv/byte_ring_fifo_with_drain_flag_test.sv =====
// Testbench top for the byte ring FIFO: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module byte_ring_fifo_with_drain_flag_test;
  import brfifo_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_PAD      = 8;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation;
  logic [DATA_W-1:0] in_data_in;
  logic              out_valid;
  logic              out_stall;
  logic [STAT_W-1:0] out_status;
  logic [DATA_W-1:0] out_data_out;
  logic              out_full_flag;
  logic              out_empty_flag;
  int                error_count;
  int                results_pending;
  int                quiet_cycles;
  bit                rx_idle_on;
  bit                long_hold_req;

  always #5 clk = ~clk;

  byte_ring_fifo_with_drain_flag u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_full_flag  (out_full_flag),
    .out_empty_flag (out_empty_flag)
  );

  byte_ring_fifo_with_drain_flag_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_data_in      (in_data_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_full_flag   (out_full_flag),
    .out_empty_flag  (out_empty_flag),
    .error_count     (error_count),
    .results_pending (results_pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (!rx_idle_on) burst_left = 0;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else begin
        out_stall <= 1'b0;
        if (rx_idle_on && $urandom_range(0, 11) == 0) burst_left = $urandom_range(1, 17);
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data_byte);
    in_valid <= 1'b1;
    in_operation <= op;
    in_data_in <= data_byte;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 17)) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic write_ring_size(input logic [CFG_W-1:0] size);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] size, input int n_items,
                           input int put_pct, input int flush_pct,
                           input bit idling, input bit hold_off);
    int pick;
    write_ring_size(size);
    rx_idle_on = idling;
    if (hold_off) long_hold_req = 1'b1;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < put_pct) begin
        send_item(OP_PUT, DATA_W'($urandom_range(0, 255)));
      end else if (pick < put_pct + flush_pct) begin
        send_item(OP_FLUSH, DATA_W'($urandom_range(0, 255)));
      end else if (pick == 99) begin
        send_item(OP_UNUSED, DATA_W'($urandom_range(0, 255)));
      end else begin
        send_item(OP_GET, DATA_W'($urandom_range(0, 255)));
      end
      if (idling && $urandom_range(0, 7) == 0) pause_sender();
    end
    send_item(OP_FLUSH, DATA_W'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_operation <= OP_PUT;
    in_data_in <= '0;
    rx_idle_on = 1'b0;
    long_hold_req = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset ring length: drain, flush on drained, put after drain
    send_item(OP_GET, 8'h00);
    send_item(OP_FLUSH, 8'hff);
    send_item(OP_PUT, 8'h00);
    send_item(OP_GET, 8'hff);

    write_ring_size(11'd3);
    send_item(OP_PUT, 8'hff);
    send_item(OP_PUT, 8'ha5);
    send_item(OP_PUT, 8'h5a);
    send_item(OP_PUT, 8'h11);
    send_item(OP_UNUSED, 8'hff);
    send_item(OP_GET, 8'h00);
    send_item(OP_GET, 8'h00);
    send_item(OP_PUT, 8'h3c);
    send_item(OP_GET, 8'h00);
    send_item(OP_GET, 8'h00);
    send_item(OP_GET, 8'h00);
    send_item(OP_PUT, 8'h77);
    send_item(OP_PUT, 8'h88);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_GET, 8'h00);
    send_item(OP_FLUSH, 8'h00);

    run_phase(11'd1, 60, 50, 3, 1'b1, 1'b0);
    run_phase(11'd0, 50, 50, 3, 1'b1, 1'b0);
    run_phase(11'd2, 60, 45, 4, 1'b1, 1'b0);
    run_phase(11'd8, 40, 60, 2, 1'b0, 1'b1);
    run_phase(11'd2047, 1080, 98, 0, 1'b1, 1'b0);
    run_phase(11'd16, 60, 55, 3, 1'b0, 1'b0);
    run_phase(11'd5, 60, 40, 5, 1'b1, 1'b0);
    run_phase(CFG_W'($urandom_range(1, 40)), 60, 50, 3, 1'b1, 1'b0);
    run_phase(11'd1024, 60, 50, 3, 1'b1, 1'b0);
    run_phase(11'd4, 60, 50, 3, 1'b0, 1'b0);

    wait_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    if (error_count == 0 && results_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
